### src/tans_pkg.sv
// Shared codes and control/status bundles for the tANS symbol encoder.
// No dependencies; every other file but the two channel interfaces imports this package.
`timescale 1ns / 1ps
`default_nettype none
package tans_pkg;

	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_BUILD = 2'd1;
	localparam logic [1:0] FUNC_ENC   = 2'd2;
	localparam logic [1:0] FUNC_RSVD  = 2'd3;

	localparam logic [2:0] KIND_DATA   = 3'd0;
	localparam logic [2:0] KIND_PAD    = 3'd1;
	localparam logic [2:0] KIND_POS    = 3'd2;
	localparam logic [2:0] KIND_STATE  = 3'd3;
	localparam logic [2:0] KIND_STATUS = 3'd4;
	localparam logic [2:0] KIND_NRDY   = 3'd5;

	typedef struct packed {
		logic       accept;
		logic       load;
		logic       bld_init;
		logic       freq_rd;
		logic       sum_acc;
		logic       s_inc;
		logic       sp_init;
		logic       sp_ld;
		logic       sp_wr;
		logic       ns_rd_sp;
		logic       ns_rd_fill;
		logic       ns_wr;
		logic       set_ready;
		logic       enc_rd;
		logic       enc_calc;
		logic       enc_shift;
		logic       enc_ns;
		logic       enc_upd;
		logic       clr_coder;
		logic       emit;
		logic [2:0] kind;
		logic       eor;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       last;
		logic       ready;
		logic       s_last;
		logic       cnt_zero;
		logic       u_last;
		logic       sum_ok;
		logic       emit;
		logic       pad;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

### src/tans_req_if.sv
// Input channel of the tANS encoder: valid/ready plus one request word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface tans_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  symbol;
	logic [12:0] freq_value;
	logic        last;

	modport source (output valid, output func, output symbol, output freq_value,
		output last, input ready);
	modport sink (input valid, input func, input symbol, input freq_value,
		input last, output ready);
endinterface
`default_nettype wire

### src/tans_rsp_if.sv
// Output channel of the tANS encoder: valid/ready plus one result word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface tans_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] word;
	logic        end_of_run;

	modport source (output valid, output kind, output word, output end_of_run,
		input ready);
	modport sink (input valid, input kind, input word, input end_of_run,
		output ready);
endinterface
`default_nettype wire

### src/tans_ctrl.sv
// Sequencer of the tANS encoder: table build passes, encode steps, result emission.
// Depends on tans_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tans_ctrl import tans_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [22:0] {
		ST_IDLE       = 23'h000001,
		ST_DISPATCH   = 23'h000002,
		ST_SUM_RD     = 23'h000004,
		ST_SUM_ACC    = 23'h000008,
		ST_SUM_CHK    = 23'h000010,
		ST_SP_RD      = 23'h000020,
		ST_SP_LD      = 23'h000040,
		ST_SP_WR      = 23'h000080,
		ST_NS_RD_SP   = 23'h000100,
		ST_NS_RD_FILL = 23'h000200,
		ST_NS_WR      = 23'h000400,
		ST_BLD_DONE   = 23'h000800,
		ST_BLD_ERR    = 23'h001000,
		ST_ENC_RD     = 23'h002000,
		ST_ENC_CALC   = 23'h004000,
		ST_ENC_SHIFT  = 23'h008000,
		ST_ENC_NS     = 23'h010000,
		ST_ENC_UPD    = 23'h020000,
		ST_EMIT_DATA  = 23'h040000,
		ST_EMIT_PAD   = 23'h080000,
		ST_EMIT_POS   = 23'h100000,
		ST_EMIT_STATE = 23'h200000,
		ST_EMIT_NRDY  = 23'h400000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_d   = state_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (sts.func)
					FUNC_LOAD: begin
						cmd.load = 1'b1;
						state_d  = ST_IDLE;
					end
					FUNC_BUILD: begin
						cmd.bld_init = 1'b1;
						state_d      = ST_SUM_RD;
					end
					FUNC_ENC: begin
						state_d = sts.ready ? ST_ENC_RD : ST_EMIT_NRDY;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SUM_RD: begin
				cmd.freq_rd = 1'b1;
				state_d     = ST_SUM_ACC;
			end
			ST_SUM_ACC: begin
				cmd.sum_acc = 1'b1;
				cmd.s_inc   = 1'b1;
				state_d     = sts.s_last ? ST_SUM_CHK : ST_SUM_RD;
			end
			ST_SUM_CHK: begin
				cmd.sp_init = 1'b1;
				state_d     = sts.sum_ok ? ST_SP_RD : ST_BLD_ERR;
			end
			ST_SP_RD: begin
				cmd.freq_rd = 1'b1;
				state_d     = ST_SP_LD;
			end
			ST_SP_LD: begin
				cmd.sp_ld = 1'b1;
				state_d   = ST_SP_WR;
			end
			ST_SP_WR: begin
				if (sts.cnt_zero) begin
					cmd.s_inc = 1'b1;
					state_d   = sts.s_last ? ST_NS_RD_SP : ST_SP_RD;
				end else begin
					cmd.sp_wr = 1'b1;
				end
			end
			ST_NS_RD_SP: begin
				cmd.ns_rd_sp = 1'b1;
				state_d      = ST_NS_RD_FILL;
			end
			ST_NS_RD_FILL: begin
				cmd.ns_rd_fill = 1'b1;
				state_d        = ST_NS_WR;
			end
			ST_NS_WR: begin
				cmd.ns_wr = 1'b1;
				state_d   = sts.u_last ? ST_BLD_DONE : ST_NS_RD_SP;
			end
			ST_BLD_DONE: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.kind      = KIND_STATUS;
					cmd.eor       = 1'b1;
					cmd.set_ready = 1'b1;
					cmd.clr_coder = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_BLD_ERR: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_STATUS;
					cmd.eor  = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_ENC_RD: begin
				cmd.enc_rd = 1'b1;
				state_d    = ST_ENC_CALC;
			end
			ST_ENC_CALC: begin
				cmd.enc_calc = 1'b1;
				state_d      = ST_ENC_SHIFT;
			end
			ST_ENC_SHIFT: begin
				cmd.enc_shift = 1'b1;
				state_d       = ST_ENC_NS;
			end
			ST_ENC_NS: begin
				cmd.enc_ns = 1'b1;
				state_d    = ST_ENC_UPD;
			end
			ST_ENC_UPD: begin
				cmd.enc_upd = 1'b1;
				if (sts.emit) begin
					state_d = ST_EMIT_DATA;
				end else if (sts.last) begin
					state_d = sts.pad ? ST_EMIT_PAD : ST_EMIT_POS;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_DATA: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_DATA;
					cmd.eor  = !sts.last;
					if (sts.last) begin
						state_d = sts.pad ? ST_EMIT_PAD : ST_EMIT_POS;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT_PAD: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_PAD;
					state_d  = ST_EMIT_POS;
				end
			end
			ST_EMIT_POS: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_POS;
					state_d  = ST_EMIT_STATE;
				end
			end
			ST_EMIT_STATE: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.kind      = KIND_STATE;
					cmd.eor       = 1'b1;
					cmd.clr_coder = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_EMIT_NRDY: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_NRDY;
					cmd.eor  = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

### src/tans_dp.sv
// Datapath of the tANS encoder: frequency, spread, state and delta memories,
// coder state, bit accumulator and output register. Depends on tans_pkg, tans_rsp_if.
`timescale 1ns / 1ps
`default_nettype none
module tans_dp import tans_pkg::*; #(
	parameter int TABLE_LOG = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  func,
	input  logic [7:0]  symbol,
	input  logic [12:0] freq_value,
	input  logic        last,
	tans_rsp_if.source  rsp
);

	localparam int TSIZE = 1 << TABLE_LOG;
	localparam int XW    = TABLE_LOG + 1;
	localparam int ACC_W = 32 + TABLE_LOG + 1;
	localparam int SUM_W = 21;
	localparam logic [TABLE_LOG-1:0] STEP =
		TABLE_LOG'((TSIZE >> 1) + (TSIZE >> 3) + 3);

	function automatic logic [3:0] flog2(input logic [12:0] v);
		logic [3:0] r;
		r = 4'd0;
		for (int i = 1; i < 13; i++) begin
			if (v[i]) r = 4'(i);
		end
		return r;
	endfunction

	logic [1:0]  func_q;
	logic [7:0]  sym_q;
	logic [12:0] fv_q;
	logic        last_q;

	logic [12:0] freq_mem [256];
	logic [255:0] fvalid_q;
	logic [12:0] freq_rd_q;
	logic        fvld_rd_q;
	logic [7:0]  spread_mem [TSIZE];
	logic [7:0]  sp_rd_q;
	logic [XW-1:0] ns_mem [TSIZE];
	logic [XW-1:0] ns_rd_q;
	logic [TABLE_LOG-1:0] fill_mem [256];
	logic [TABLE_LOG-1:0] fill_rd_q;
	logic [19:0] nbd_mem [256];
	logic [19:0] nbd_rd_q;
	logic [TABLE_LOG-1:0] fd_mem [256];
	logic [TABLE_LOG-1:0] fd_rd_q;

	logic [7:0]  s_q;
	logic [TABLE_LOG-1:0] u_q;
	logic [TABLE_LOG-1:0] pos_q;
	logic [12:0] cnt_sp_q;
	logic [SUM_W-1:0] sum_q;
	logic        ready_q;

	logic [XW-1:0]    coder_q;
	logic [ACC_W-1:0] acc_q;
	logic [5:0]       cnt_q;
	logic [4:0]       nb_q;
	logic [TABLE_LOG-1:0] idx_q;
	logic             emit_q;
	logic [31:0]      data_q;

	logic        out_v_q;
	logic [2:0]  out_kind_q;
	logic [31:0] out_word_q;
	logic        out_eor_q;

	logic [12:0] f_eff;
	logic [4:0]  mb;
	logic [20:0] fsh;
	logic [20:0] nbd_full;
	logic [19:0] nbd_wr;
	logic [TABLE_LOG-1:0] fd_wr;
	logic [20:0] nb_sum;
	logic [XW-1:0] low_mask;
	logic [5:0]  pad_sh;
	logic [31:0] word_sel;
	logic [TABLE_LOG-1:0] fill_wa;
	logic [TABLE_LOG-1:0] fill_wd;
	logic [7:0]  fill_addr;

	assign f_eff    = fvld_rd_q ? freq_rd_q : 13'd0;
	assign mb       = 5'(TABLE_LOG) - {1'b0, flog2(f_eff - 13'd1)};
	assign fsh      = {8'd0, f_eff} << mb;
	assign nbd_full = {mb, 16'd0} - fsh;
	assign nbd_wr   = (f_eff == 13'd0) ? 20'd0 : nbd_full[19:0];
	assign fd_wr    = (f_eff == 13'd0) ? '0 : TABLE_LOG'(sum_q - SUM_W'(f_eff));
	assign nb_sum   = 21'(coder_q) + {1'b0, nbd_rd_q};
	assign low_mask = ~({XW{1'b1}} << nb_q);
	assign pad_sh   = 6'd32 - cnt_q;
	assign fill_addr = cmd.ns_wr ? sp_rd_q : s_q;
	assign fill_wd  = cmd.ns_wr ? fill_rd_q + 1'b1 : sum_q[TABLE_LOG-1:0];
	assign fill_wa  = '0;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= func;
			sym_q  <= symbol;
			fv_q   <= freq_value;
			last_q <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) freq_mem[sym_q] <= fv_q;
		if (cmd.freq_rd) freq_rd_q <= freq_mem[s_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvalid_q  <= '0;
			fvld_rd_q <= 1'b0;
		end else begin
			if (cmd.load) fvalid_q[sym_q] <= 1'b1;
			if (cmd.freq_rd) fvld_rd_q <= fvalid_q[s_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sp_wr) spread_mem[pos_q] <= s_q;
		if (cmd.ns_rd_sp) sp_rd_q <= spread_mem[u_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_acc || cmd.ns_wr) fill_mem[fill_addr] <= fill_wd | fill_wa;
		if (cmd.ns_rd_fill) fill_rd_q <= fill_mem[sp_rd_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.ns_wr) ns_mem[fill_rd_q] <= {1'b1, u_q};
		if (cmd.enc_ns) ns_rd_q <= ns_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_acc) begin
			nbd_mem[s_q] <= nbd_wr;
			fd_mem[s_q]  <= fd_wr;
		end
		if (cmd.enc_rd) begin
			nbd_rd_q <= nbd_mem[sym_q];
			fd_rd_q  <= fd_mem[sym_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q      <= '0;
			u_q      <= '0;
			pos_q    <= '0;
			cnt_sp_q <= '0;
			sum_q    <= '0;
			ready_q  <= 1'b0;
		end else begin
			if (cmd.bld_init) begin
				s_q     <= '0;
				sum_q   <= '0;
				ready_q <= 1'b0;
			end
			if (cmd.load) ready_q <= 1'b0;
			if (cmd.set_ready) ready_q <= 1'b1;
			if (cmd.sum_acc) sum_q <= sum_q + SUM_W'(f_eff);
			if (cmd.s_inc) s_q <= s_q + 8'd1;
			if (cmd.sp_init) begin
				pos_q <= '0;
				u_q   <= '0;
			end
			if (cmd.sp_ld) cnt_sp_q <= f_eff;
			if (cmd.sp_wr) begin
				pos_q    <= pos_q + STEP;
				cnt_sp_q <= cnt_sp_q - 13'd1;
			end
			if (cmd.ns_wr) u_q <= u_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coder_q <= XW'(TSIZE);
			acc_q   <= '0;
			cnt_q   <= '0;
			emit_q  <= 1'b0;
		end else begin
			if (cmd.enc_shift) begin
				acc_q <= (acc_q << nb_q) | ACC_W'(coder_q & low_mask);
				cnt_q <= cnt_q + {1'b0, nb_q};
			end
			if (cmd.enc_ns) begin
				emit_q <= (cnt_q >= 6'd32);
				if (cnt_q >= 6'd32) cnt_q <= cnt_q - 6'd32;
			end
			if (cmd.enc_upd) coder_q <= ns_rd_q;
			if (cmd.clr_coder) begin
				coder_q <= XW'(TSIZE);
				acc_q   <= '0;
				cnt_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enc_calc) nb_q <= nb_sum[20:16];
		if (cmd.enc_shift) idx_q <= TABLE_LOG'((coder_q >> nb_q) + XW'(fd_rd_q));
		if (cmd.enc_ns) data_q <= 32'(acc_q >> (cnt_q - 6'd32));
	end

	always_comb begin
		case (cmd.kind)
			KIND_DATA:   word_sel = data_q;
			KIND_PAD:    word_sel = 32'(acc_q << pad_sh);
			KIND_POS:    word_sel = (cnt_q == 6'd0) ? 32'd0 : 32'(pad_sh);
			KIND_STATE:  word_sel = 32'(coder_q[TABLE_LOG-1:0]);
			KIND_STATUS: word_sel = {31'd0, sum_q != SUM_W'(TSIZE)};
			default:     word_sel = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.emit) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.kind;
			out_word_q <= word_sel;
			out_eor_q  <= cmd.eor;
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.kind       = out_kind_q;
	assign rsp.word       = out_word_q;
	assign rsp.end_of_run = out_eor_q;

	assign sts.func     = func_q;
	assign sts.last     = last_q;
	assign sts.ready    = ready_q;
	assign sts.s_last   = (s_q == 8'd255);
	assign sts.cnt_zero = (cnt_sp_q == 13'd0);
	assign sts.u_last   = &u_q;
	assign sts.sum_ok   = (sum_q == SUM_W'(TSIZE));
	assign sts.emit     = emit_q;
	assign sts.pad      = (cnt_q != 6'd0);
	assign sts.out_free = !out_v_q || rsp.ready;

endmodule
`default_nettype wire

### src/tans_fse_symbol_encoder_core.sv
// Top level of the tANS (FSE) byte encoder: sequencer plus datapath.
// Depends on tans_pkg, tans_req_if, tans_rsp_if, tans_ctrl, tans_dp.
//
//   channel | modport | word carries
//   req     | sink    | func, symbol, freq_value, last
//   rsp     | source  | kind, word, end_of_run
//
// Load writes one frequency. Encode reads the symbol's deltas, computes the bit count,
// shifts the accumulator, reads the next state and updates the coder, then emits any
// result words, each waiting while rsp is not free. Build sums the frequencies, spreads
// the symbols into the spread memory, fills the state table, then emits the status word.
// req is taken only in idle; a stalled rsp holds the sequencer in its emit step.
// Reset clears frequencies (valid bits), the coder and the ready flag at once.
`timescale 1ns / 1ps
`default_nettype none
module tans_fse_symbol_encoder_core import tans_pkg::*; #(
	parameter int TABLE_LOG = 12
) (
	input logic        clk,
	input logic        arst_n,
	tans_req_if.sink   req,
	tans_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;
	logic req_ready;

	assign req.ready = req_ready;

	tans_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tans_dp #(
		.TABLE_LOG (TABLE_LOG)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (req.func),
		.symbol     (req.symbol),
		.freq_value (req.freq_value),
		.last       (req.last),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire

### src/tans_chk.sv
// Port-level checks of the tANS encoder, bound to the top level.
// Depends on tans_pkg and tans_fse_symbol_encoder_core.
`timescale 1ns / 1ps
`default_nettype none
module tans_core_chk import tans_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_kind,
	input logic [31:0] rsp_word,
	input logic        rsp_end_of_run
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_word))
		else $error("rsp word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req taken twice in a row");

	a_single_kinds_end: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == KIND_STATE || rsp_kind == KIND_STATUS ||
		rsp_kind == KIND_NRDY) |-> rsp_end_of_run)
		else $error("closing word without end_of_run");

	a_flush_middle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == KIND_PAD || rsp_kind == KIND_POS) |-> !rsp_end_of_run)
		else $error("flush word marked as end_of_run");

endmodule

bind tans_fse_symbol_encoder_core tans_core_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_kind       (rsp.kind),
	.rsp_word       (rsp.word),
	.rsp_end_of_run (rsp.end_of_run)
);
`default_nettype wire

### test/tans_chk.sv
// Scoreboard for the tANS symbol encoder: watches both channels, predicts words.
// Depends on tans_pkg, tans_req_if and tans_rsp_if.
`timescale 1ns / 1ps
module tans_chk import tans_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	tans_req_if    req,
	tans_rsp_if    rsp,
	output int     fails,
	output int     pending
);
	localparam int TLOG = 12;
	localparam int TSZ  = 1 << TLOG;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] word;
		logic        eor;
	} enc_word_t;

	enc_word_t    want_q[$];
	logic [12:0]  frq[256];
	logic [7:0]   spread[TSZ];
	int           nstate[TSZ];
	int           nb_dlt[256];
	int           fd_dlt[256];
	int           cstate;
	logic [63:0]  acc;
	int           nbits;
	bit           tbl_ok;

	initial begin
		fails = 0;
		pending = 0;
		for (int i = 0; i < 256; i++) frq[i] = '0;
		tbl_ok = 0;
		cstate = TSZ;
		acc = '0;
		nbits = 0;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
		fails++;
	endtask

	task automatic push(input logic [2:0] k, input logic [31:0] w);
		enc_word_t e;
		e.kind = k;
		e.word = w;
		e.eor  = 1'b0;
		want_q.push_back(e);
	endtask

	function automatic int msb_pos(input int v);
		int r;
		r = 0;
		while (v > 1) begin
			v = v >> 1;
			r++;
		end
		return r;
	endfunction

	function automatic logic [31:0] build_tables();
		int sum, pos, tot, f, mb, sym;
		int fill[256];
		sum = 0;
		pos = 0;
		tot = 0;
		for (int s = 0; s < 256; s++) sum += frq[s];
		if (sum != TSZ) begin
			tbl_ok = 0;
			return 32'd1;
		end
		for (int s = 0; s < 256; s++)
			for (int i = 0; i < frq[s]; i++) begin
				spread[pos] = s[7:0];
				pos = (pos + (TSZ >> 1) + (TSZ >> 3) + 3) & (TSZ - 1);
			end
		for (int s = 0; s < 256; s++) begin
			fill[s] = tot;
			tot += frq[s];
		end
		for (int u = 0; u < TSZ; u++) begin
			sym = spread[u];
			nstate[fill[sym] & (TSZ - 1)] = TSZ + u;
			fill[sym]++;
		end
		tot = 0;
		for (int s = 0; s < 256; s++) begin
			f = frq[s];
			if (f == 0) begin
				nb_dlt[s] = 0;
				fd_dlt[s] = 0;
			end else if (f == 1) begin
				nb_dlt[s] = (TLOG << 16) - TSZ;
				fd_dlt[s] = tot - 1;
			end else begin
				mb = TLOG - msb_pos(f - 1);
				nb_dlt[s] = (mb << 16) - (f << mb);
				fd_dlt[s] = tot - f;
			end
			tot += f;
		end
		tbl_ok = 1;
		cstate = TSZ;
		acc = '0;
		nbits = 0;
		return 32'd0;
	endfunction

	task automatic predict(input logic [1:0] fn, input logic [7:0] sym, input logic [12:0] fv,
		input logic lst);
		int n0, nb, x, pos0;
		logic [63:0] sh;
		n0 = want_q.size();
		if (fn == FUNC_LOAD) begin
			frq[sym] = fv;
			tbl_ok = 0;
		end else if (fn == FUNC_BUILD) begin
			push(KIND_STATUS, build_tables());
		end else if (fn == FUNC_ENC && !tbl_ok) begin
			push(KIND_NRDY, 32'd0);
		end else if (fn == FUNC_ENC) begin
			x = cstate;
			nb = ((x + nb_dlt[sym]) >> 16) & 31;
			acc = (acc << nb) | 64'(x & ((1 << nb) - 1));
			nbits += nb;
			if (nbits >= 32) begin
				sh = acc >> (nbits - 32);
				push(KIND_DATA, sh[31:0]);
				nbits -= 32;
				acc &= (64'd1 << nbits) - 64'd1;
			end
			cstate = nstate[((x >> nb) + fd_dlt[sym]) & (TSZ - 1)];
			if (lst) begin
				pos0 = 0;
				if (nbits > 0) begin
					pos0 = 32 - nbits;
					sh = acc << pos0;
					push(KIND_PAD, sh[31:0]);
				end
				push(KIND_POS, 32'(pos0));
				push(KIND_STATE, 32'(cstate - TSZ));
				cstate = TSZ;
				acc = '0;
				nbits = 0;
			end
		end
		if (want_q.size() > n0) want_q[want_q.size() - 1].eor = 1'b1;
	endtask

	always @(posedge clk) begin
		enc_word_t e;
		if (arst_n) begin
			if (req.valid && req.ready) predict(req.func, req.symbol, req.freq_value, req.last);
			if (rsp.valid && rsp.ready) begin
				if (want_q.size() == 0) begin
					report("unexpected word", rsp.word, 32'd0);
				end else begin
					e = want_q.pop_front();
					if (rsp.kind !== e.kind) report("kind", 32'(rsp.kind), 32'(e.kind));
					if (rsp.word !== e.word) report("word", rsp.word, e.word);
					if (rsp.end_of_run !== e.eor)
						report("end_of_run", 32'(rsp.end_of_run), 32'(e.eor));
				end
			end
			pending = want_q.size();
		end
	end
endmodule

### test/tb_top.sv
// Top of the tANS encoder testbench: clock, reset, stimulus and verdict.
// Depends on tans_pkg, both channel interfaces, tans_chk and the encoder core.
`timescale 1ns / 1ps
module tb_top;
	import tans_pkg::*;

	logic clk;
	logic arst_n;
	int   fails, pending;
	int   tx_idle, rx_idle;
	int   n_items;
	int   cycles;
	bit   hold_rq;
	logic [12:0] cur_frq[256];
	logic [7:0]  live[$];

	tans_req_if req();
	tans_rsp_if rsp();

	tans_fse_symbol_encoder_core u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	tans_chk u_chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fails(fails), .pending(pending));

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rq) begin
				rsp.ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_rq = 0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	task automatic send(input logic [1:0] fn, input logic [7:0] sym, input logic [12:0] fv,
		input logic lst);
		int gap;
		if ($urandom_range(99) < tx_idle) begin
			req.valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.func       <= fn;
		req.symbol     <= sym;
		req.freq_value <= fv;
		req.last       <= lst;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		if (fn != FUNC_RSVD) n_items++;
		@(negedge clk);
	endtask

	task automatic set_freq(input logic [7:0] sym, input logic [12:0] fv);
		send(FUNC_LOAD, sym, fv, 1'b0);
		cur_frq[sym] = fv;
	endtask

	// zero the old table, then load a random set summing to the table size (short of it when spoil skips the first symbol)
	task automatic load_set(input int nsym, input bit spoil);
		int rem, a;
		logic [7:0] s;
		bit used[256];
		for (int i = 0; i < 256; i++) begin
			if (cur_frq[i] != 0) set_freq(i[7:0], 13'd0);
			used[i] = 0;
		end
		live.delete();
		rem = 4096 - nsym;
		for (int i = 0; i < nsym; i++) begin
			do s = 8'($urandom_range(255)); while (used[s]);
			used[s] = 1;
			a = (i == nsym - 1) ? rem : $urandom_range(0, rem / 2);
			rem -= a;
			live.push_back(s);
			if (!(spoil && i == 0)) set_freq(s, 13'(a + 1));
		end
	endtask

	task automatic lane(input int len);
		logic [7:0] s;
		for (int i = 0; i < len; i++) begin
			if (live.size() > 0 && $urandom_range(9) != 0)
				s = live[$urandom_range(live.size() - 1)];
			else
				s = 8'($urandom_range(255));
			send(FUNC_ENC, s, 13'($urandom_range(8191)), i == len - 1);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.func = FUNC_LOAD;
		req.symbol = '0;
		req.freq_value = '0;
		req.last = 1'b0;
		hold_rq = 0;
		n_items = 0;
		tx_idle = 6;
		rx_idle = 84;
		for (int i = 0; i < 256; i++) cur_frq[i] = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed
		send(FUNC_ENC, 8'd0, 13'd0, 1'b1);
		send(FUNC_RSVD, 8'hff, 13'h1fff, 1'b1);
		send(FUNC_BUILD, 8'd0, 13'd0, 1'b0);
		set_freq(8'd255, 13'd4095);
		set_freq(8'd0, 13'd1);
		send(FUNC_ENC, 8'd255, 13'd0, 1'b0);
		send(FUNC_BUILD, 8'hff, 13'h1fff, 1'b1);
		live = '{8'd0, 8'd255};
		send(FUNC_ENC, 8'd0, 13'd0, 1'b0);
		send(FUNC_ENC, 8'd255, 13'd0, 1'b0);
		send(FUNC_ENC, 8'd7, 13'd0, 1'b0);
		send(FUNC_ENC, 8'd0, 13'd0, 1'b0);
		send(FUNC_ENC, 8'd0, 13'd0, 1'b1);
		send(FUNC_ENC, 8'd255, 13'd0, 1'b1);
		set_freq(8'd255, 13'd0);
		set_freq(8'd0, 13'd0);
		set_freq(8'h55, 13'd4096);
		send(FUNC_BUILD, 8'd0, 13'd0, 1'b0);
		live = '{8'h55};
		send(FUNC_ENC, 8'h55, 13'd0, 1'b1);
		send(FUNC_ENC, 8'haa, 13'd0, 1'b1);

		// random
		while (n_items < 470) begin
			if (n_items > 320 && tx_idle != 0) begin
				tx_idle = 0;
				rx_idle = 0;
				hold_rq = 1;
			end else if (n_items > 170 && n_items <= 320 && tx_idle == 6) begin
				tx_idle = 84;
				rx_idle = 6;
			end
			case ($urandom_range(19))
				0: begin
					load_set($urandom_range(1, 40), $urandom_range(3) == 0);
					send(FUNC_BUILD, 8'($urandom_range(255)), 13'($urandom_range(8191)),
						1'($urandom_range(1)));
				end
				1: send(FUNC_RSVD, 8'($urandom_range(255)), 13'($urandom_range(8191)),
					1'($urandom_range(1)));
				default: lane($urandom_range(1, 30));
			endcase
		end
		req.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

### sim.f
src/tans_pkg.sv
src/tans_req_if.sv
src/tans_rsp_if.sv
src/tans_ctrl.sv
src/tans_dp.sv
src/tans_fse_symbol_encoder_core.sv
src/tans_chk.sv
test/tans_chk.sv
test/tb_top.sv
